>>> rtl/core/nspc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-seed classifier package
// Word types of both channels, operation, metric and register codes.
// ----------------------------------------------------------------------------
package nspc_pkg;

  localparam int AREA_W = 21;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
  localparam int IN_COORD_W = 10;
  localparam int OUT_INDEX_W = 6;
  localparam int CFG_DATA_W = 7;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLASSIFY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] METRIC_EUCLID = 2'd0;
  localparam logic [1:0] METRIC_MANHATTAN = 2'd1;
  localparam logic [1:0] METRIC_CHEBYSHEV = 2'd2;

  localparam logic REG_METRIC = 1'b0;
  localparam logic REG_SEED_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] seed_index;
    logic [IN_COORD_W-1:0] coord_x;
    logic [IN_COORD_W-1:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic has_seed;
    logic [OUT_INDEX_W-1:0] nearest_seed;
    logic [AREA_W-1:0] area_count;
  } out_word_t;

endpackage
`default_nettype wire

>>> rtl/core/nspc_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Distance pipeline
// Three stages from a seed and a pixel to the distance under the metric.
// ----------------------------------------------------------------------------
module nspc_dist #(
  parameter int COORD_BITS = 10,
  parameter int IDX_W = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [1:0] metric,
  input  wire logic [COORD_BITS-1:0] px,
  input  wire logic [COORD_BITS-1:0] py,
  input  wire logic [COORD_BITS-1:0] sx,
  input  wire logic [COORD_BITS-1:0] sy,
  input  wire logic in_valid,
  input  wire logic [IDX_W-1:0] in_idx,
  output logic out_valid,
  output logic [IDX_W-1:0] out_idx,
  output logic [2*COORD_BITS:0] out_dist
);
  import nspc_pkg::*;

  localparam int DIST_W = 2 * COORD_BITS + 1;
  localparam int SQ_W = 2 * COORD_BITS;

  logic v1, v2;
  logic [IDX_W-1:0] idx1, idx2;
  logic [COORD_BITS-1:0] dx1, dy1, dx2, dy2;
  logic [2*COORD_BITS-1:0] sqx2, sqy2;
  logic [DIST_W-1:0] dist_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_comb begin
    case (metric)
      METRIC_EUCLID: dist_next = DIST_W'(sqx2) + DIST_W'(sqy2);
      METRIC_MANHATTAN: dist_next = DIST_W'(dx2) + DIST_W'(dy2);
      METRIC_CHEBYSHEV: dist_next = (dx2 > dy2) ? DIST_W'(dx2) : DIST_W'(dy2);
      default: dist_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    idx1 <= in_idx;
    dx1 <= (px > sx) ? px - sx : sx - px;
    dy1 <= (py > sy) ? py - sy : sy - py;
    idx2 <= idx1;
    dx2 <= dx1;
    dy2 <= dy1;
    sqx2 <= SQ_W'(dx1) * SQ_W'(dx1);
    sqy2 <= SQ_W'(dy1) * SQ_W'(dy1);
    out_idx <= idx2;
    out_dist <= dist_next;
  end

endmodule
`default_nettype wire

>>> rtl/core/nearest_seed_pixel_classifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-seed pixel classifier
// Voronoi labelling over a seed table with per-seed area counters.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_ready and each gives exactly one output
// word on out_valid/out_ready, held in an output register. Items are handled
// one at a time; in_ready is high only while the block is idle.
// For a classify word with a nonzero seed_count, the seed memory is read one
// entry a cycle into a three-stage distance pipeline, then the winner's area
// counter is read, incremented and written back. A clear word sweeps the area
// counter memory one entry a cycle. After reset the same sweep zeroes the
// counters, with in_ready low; configuration writes are taken throughout.
// When the receiver stalls, a finished word waits in the output register and
// the next result waits in the block until the register frees up.
// Configuration is written on cfg_write with cfg_index and cfg_data. The user
// must write it only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module nearest_seed_pixel_classifier_unit #(
  parameter int MAX_SEEDS = 64,
  parameter int COORD_BITS = 10
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write,
  input  wire logic cfg_index,
  input  wire logic [nspc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire nspc_pkg::in_word_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output nspc_pkg::out_word_t out_data
);
  import nspc_pkg::*;

  localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int DIST_W = 2 * COORD_BITS + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SEEDS - 1);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_DRAIN   = 7'b0001000,
    S_AREA_RD = 7'b0010000,
    S_AREA_WR = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state;
  logic [1:0] metric;
  logic [CFG_DATA_W-1:0] seed_count;
  logic [IDX_W-1:0] clr_addr;
  logic clr_reply;
  logic [IDX_W-1:0] scan_idx, scan_last;
  logic issue_done;
  logic [COORD_BITS-1:0] px, py;
  logic [IDX_W-1:0] best;
  logic [DIST_W-1:0] best_dist;
  out_word_t res;

  logic [2*COORD_BITS-1:0] seed_mem [MAX_SEEDS];
  logic [2*COORD_BITS-1:0] seed_q;
  logic s0_valid;
  logic [IDX_W-1:0] s0_idx;
  logic [AREA_W-1:0] area_mem [MAX_SEEDS];
  logic [AREA_W-1:0] area_q;
  logic [AREA_W-1:0] area_next;

  logic accept;
  logic issue;
  logic seed_we;
  logic [CNT_W-1:0] n_seeds;
  logic d_valid;
  logic [IDX_W-1:0] d_idx;
  logic [DIST_W-1:0] d_dist;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign issue = (state == S_SCAN) && !issue_done;
  assign seed_we = accept && (in_data.operation == OP_WRITE) &&
                   (int'(in_data.seed_index) < MAX_SEEDS);
  assign n_seeds = (int'(seed_count) > MAX_SEEDS) ? CNT_W'(MAX_SEEDS) : CNT_W'(seed_count);
  assign area_next = (area_q == AREA_MAX) ? area_q : area_q + AREA_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= METRIC_EUCLID;
      seed_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_METRIC: metric <= cfg_data[1:0];
        REG_SEED_COUNT: seed_count <= cfg_data;
        default: metric <= metric;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (seed_we) begin
      seed_mem[IDX_W'(in_data.seed_index)] <= {COORD_BITS'(in_data.coord_y),
                                              COORD_BITS'(in_data.coord_x)};
    end
    if (issue) begin
      seed_q <= seed_mem[scan_idx];
    end
    s0_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      area_mem[clr_addr] <= '0;
    end else if (state == S_AREA_WR) begin
      area_mem[best] <= area_next;
    end
    if (state == S_AREA_RD) begin
      area_q <= area_mem[best];
    end
  end

  nspc_dist #(
    .COORD_BITS(COORD_BITS),
    .IDX_W(IDX_W)
  ) u_dist (
    .clk(clk),
    .rst(rst),
    .metric(metric),
    .px(px),
    .py(py),
    .sx(seed_q[COORD_BITS-1:0]),
    .sy(seed_q[2*COORD_BITS-1:COORD_BITS]),
    .in_valid(s0_valid),
    .in_idx(s0_idx),
    .out_valid(d_valid),
    .out_idx(d_idx),
    .out_dist(d_dist)
  );

  always_ff @(posedge clk) begin
    if (d_valid && ((d_idx == '0) || (d_dist < best_dist))) begin
      best <= d_idx;
      best_dist <= d_dist;
    end
    if (accept) begin
      px <= COORD_BITS'(in_data.coord_x);
      py <= COORD_BITS'(in_data.coord_y);
      scan_last <= IDX_W'(n_seeds - CNT_W'(1));
    end
    if (state == S_AREA_WR) begin
      res.has_seed <= 1'b1;
      res.nearest_seed <= OUT_INDEX_W'(best);
      res.area_count <= area_next;
    end else if (accept) begin
      res <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      clr_reply <= 1'b0;
      scan_idx <= '0;
      issue_done <= 1'b0;
      s0_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s0_valid <= issue;
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == LAST_IDX) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (in_data.operation)
              OP_CLASSIFY: begin
                scan_idx <= '0;
                issue_done <= 1'b0;
                state <= (n_seeds == '0) ? S_DONE : S_SCAN;
              end
              OP_CLEAR: begin
                clr_addr <= '0;
                clr_reply <= 1'b1;
                state <= S_CLEAR;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + IDX_W'(1);
            if (scan_idx == scan_last) begin
              issue_done <= 1'b1;
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (d_valid && (d_idx == scan_last)) begin
            state <= S_AREA_RD;
          end
        end
        S_AREA_RD: state <= S_AREA_WR;
        S_AREA_WR: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data <= res;
            clr_reply <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> (d_idx <= scan_last))
    else $error("distance result beyond the scanned seed range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("new word taken while the previous one is in progress");

  a_winner_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_AREA_RD) |-> (best <= scan_last))
    else $error("winning seed outside the scanned range");

  a_done_has_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!out_valid || out_ready) |=> out_valid && (state == S_IDLE))
    else $error("finished word not moved to the output register");

endmodule
`default_nettype wire
